// ===== rtl/core/isfb_pkg.sv =====
// isfb_pkg: shared constants and types for the idle/sleep/fade/breathe block.
// No dependencies.
`timescale 1ns / 1ps
package isfb_pkg;
    localparam int          PULSE_STEPS     = 1024;
    localparam logic [31:0] DEFAULT_IDLE_MS = 32'd300000;
    localparam logic [15:0] MS_PER_MINUTE   = 16'd60000;
    localparam logic [15:0] FADE_RESET      = 16'd800;
    localparam logic [15:0] BREATHE_RESET   = 16'd4800;
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_FADE    = 2'd1;
    localparam logic [1:0] REG_BREATHE = 2'd2;
    localparam logic [1:0] REG_UNUSED  = 2'd3;
endpackage

// ===== rtl/core/isfb_divider.sv =====
// isfb_divider: restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module isfb_divider #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 18
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;

    assign trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!diff[DEN_W+1]) begin
                    r_reg <= diff[DEN_W:0];
                    q_reg <= {q_reg[NUM_W-2:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[DEN_W-1:0];
endmodule

// ===== rtl/core/isfb_multiplier.sv =====
// isfb_multiplier: shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module isfb_multiplier #(
    parameter int A_W = 32,
    parameter int B_W = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] prod
);
    localparam int CNT_W = $clog2(B_W + 1);
    logic [A_W+B_W-1:0] acc_reg, a_reg;
    logic [B_W-1:0]     b_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= '0;
                a_reg    <= {{B_W{1'b0}}, a};
                b_reg    <= b;
                cnt_reg  <= CNT_W'(B_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (b_reg[0]) acc_reg <= acc_reg + a_reg;
                a_reg   <= {a_reg[A_W+B_W-2:0], 1'b0};
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
    assign done = done_reg;
    assign prod = acc_reg;
endmodule

// ===== rtl/core/idle_sleep_fade_breathe.sv =====
// Channel | beat fields (low bit first)              | handshake
// s_      | time_ms[31:0], activity (tuser)           | s_tvalid/s_tready
// m_      | fade_scale[16:0], pulse_brightness[24:17] | m_tvalid/m_tready
//         | tuser: is_sleeping[0], is_fading[1]       |
// One tick at a time: s_tready is high only in idle. An awake tick puts its result
// on m_tvalid through ST_UPD (mode update) and ST_OUT (output load); a fading tick adds
// one divide, a fade that starts with zero length skips it. A sleeping tick runs two
// divides, four multiplies and a shift; the 34-bit bit-serial divider dominates. The
// next beat can be taken in the cycle after the result loads. aresetn is synchronous;
// a stalled result holds the output, and the next result waits in ST_OUT, s_tready low.
`timescale 1ns / 1ps
module idle_sleep_fade_breathe
    import isfb_pkg::*;
#(
    parameter int MAX_STATUS_BRIGHTNESS = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // time_ms
    input  logic        s_tuser,   // activity
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // fade_scale[16:0], pulse_brightness[24:17], zero pad
    output logic [1:0]  m_tuser,   // is_sleeping, is_fading
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    localparam int SB = $clog2(PULSE_STEPS);   // S = 2^SB
    localparam int DN = 34;
    localparam int DD = 18;

    typedef enum logic [3:0] {
        ST_IDLE, ST_UPD, ST_FADE, ST_PH, ST_X, ST_X2, ST_CUBE, ST_SM,
        ST_SQ, ST_LVL, ST_BR, ST_OUT, ST_WAIT
    } state_t;
    state_t state_reg;

    logic [9:0]  tmo_reg;
    logic [15:0] fade_len_reg, period_reg;
    logic [31:0] last_act_reg, fade_start_reg, now_reg;
    logic        act_reg, fade_reg, sleep_reg;
    logic [31:0] work_reg;
    logic [16:0] per_reg, half_reg;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic [1:0]  m_user_reg;

    logic          dv_start, dv_done, mu_start, mu_done;
    logic [DN-1:0] dv_num, dv_q;
    logic [DD-1:0] dv_den, dv_r;
    logic [31:0]   mu_a;
    logic [15:0]   mu_b;
    logic [47:0]   mu_p;

    isfb_divider #(.NUM_W(DN), .DEN_W(DD)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .num(dv_num), .den(dv_den),
        .done(dv_done), .quot(dv_q), .rem(dv_r));
    isfb_multiplier #(.A_W(32), .B_W(16)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mu_start), .a(mu_a), .b(mu_b),
        .done(mu_done), .prod(mu_p));

    logic [31:0] limit, idle_e, fade_e;
    logic [25:0] tmo_ms;
    assign tmo_ms = 26'(tmo_reg) * 26'(MS_PER_MINUTE);
    assign limit  = (tmo_reg == '0) ? DEFAULT_IDLE_MS : 32'(tmo_ms);
    assign idle_e = now_reg - last_act_reg;
    assign fade_e = now_reg - fade_start_reg;

    logic [16:0] ph, r_val;
    assign ph    = dv_r[16:0];
    assign r_val = (ph < half_reg) ? ph : per_reg - ph;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    logic [31:0] x_reg;
    logic [2:0]  phase_reg;
    logic [16:0] scale_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tmo_reg      <= '0;
            fade_len_reg <= FADE_RESET;
            period_reg   <= BREATHE_RESET;
            last_act_reg <= '0;
            fade_start_reg <= '0;
            fade_reg     <= 1'b0;
            sleep_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TIMEOUT: tmo_reg      <= cfg_wdata[9:0];
                    REG_FADE:    fade_len_reg <= cfg_wdata;
                    REG_BREATHE: period_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready && state_reg != ST_OUT) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    now_reg   <= s_tdata;
                    act_reg   <= s_tuser;
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (act_reg) begin
                        last_act_reg <= now_reg;
                        fade_reg  <= 1'b0;
                        sleep_reg <= 1'b0;
                        work_reg  <= 32'h10000;
                        state_reg <= ST_OUT;
                    end else if (sleep_reg) begin
                        state_reg <= ST_PH;
                    end else if (fade_reg) begin
                        if (fade_e >= 32'(fade_len_reg)) begin
                            fade_reg  <= 1'b0;
                            sleep_reg <= 1'b1;
                            state_reg <= ST_PH;
                        end else state_reg <= ST_FADE;
                    end else if (idle_e >= limit) begin
                        fade_reg       <= 1'b1;
                        fade_start_reg <= now_reg;
                        state_reg      <= ST_FADE;
                    end else begin
                        work_reg  <= 32'h10000;
                        state_reg <= ST_OUT;
                    end
                    per_reg  <= (period_reg < 16'd2) ? 17'd2 : {1'b0, period_reg};
                    half_reg <= ((period_reg < 16'd2) ? 17'd2 : {1'b0, period_reg}) >> 1;
                end
                ST_FADE: begin
                    // fade_start may be now (e=0) when the fade just began
                    if (phase_reg == 3'd0) begin
                        if (fade_e >= 32'(fade_len_reg)) begin
                            work_reg  <= '0;
                            state_reg <= ST_OUT;
                        end else phase_reg <= 3'd1;
                    end else if (phase_reg == 3'd1) phase_reg <= 3'd2;
                    else if (dv_done) begin
                        work_reg  <= dv_q[31:0];
                        phase_reg <= 3'd0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_PH: begin
                    if (phase_reg == 3'd1) phase_reg <= 3'd2;
                    else if (phase_reg == 3'd0) phase_reg <= 3'd1;
                    else if (dv_done) begin
                        x_reg     <= 32'(r_val) << SB;
                        phase_reg <= 3'd0;
                        state_reg <= ST_X;
                    end
                end
                ST_X: begin
                    if (phase_reg == 3'd0) phase_reg <= 3'd1;
                    else if (phase_reg == 3'd1) phase_reg <= 3'd2;
                    else if (dv_done) begin
                        x_reg     <= (dv_q > DN'(PULSE_STEPS)) ? 32'(PULSE_STEPS)
                                                              : dv_q[31:0];
                        phase_reg <= 3'd0;
                        state_reg <= ST_X2;
                    end
                end
                ST_X2, ST_CUBE, ST_SQ, ST_BR: begin
                    if (phase_reg == 3'd0) phase_reg <= 3'd1;
                    else if (phase_reg == 3'd1) phase_reg <= 3'd2;
                    else if (mu_done) begin
                        phase_reg <= 3'd0;
                        unique case (state_reg)
                            ST_X2:   begin work_reg <= mu_p[31:0]; state_reg <= ST_CUBE; end
                            ST_CUBE: begin work_reg <= mu_p[31:0] + 32'(1 << (2*SB-1));
                                           state_reg <= ST_SM; end
                            ST_SQ:   begin work_reg <= (mu_p[31:0] + 32'(PULSE_STEPS/2)) >> SB;
                                           state_reg <= ST_BR; end
                            default: begin work_reg <= (mu_p[31:0] + 32'(PULSE_STEPS/2)) >> SB;
                                           state_reg <= ST_OUT; end
                        endcase
                    end
                end
                ST_SM: begin
                    work_reg  <= work_reg >> (2*SB);
                    state_reg <= ST_SQ;
                end
                ST_OUT: if (!m_valid_reg || m_tready) begin
                    m_valid_reg <= 1'b1;
                    m_user_reg  <= {fade_reg, sleep_reg};
                    m_data_reg  <= sleep_reg ? {7'd0, work_reg[7:0], 17'd0}
                                             : {15'd0, scale_res};
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
    assign scale_res = work_reg[16:0];

    // Start pulses: issued at phase 1 of each arithmetic state.
    logic [31:0] fe_w;
    logic [16:0] fl_w;
    assign fl_w = {1'b0, fade_len_reg};
    assign fe_w = fade_e;
    always_comb begin : starts
        logic [16:0] rem_f;
        rem_f = fl_w - fe_w[16:0];
        dv_start = 1'b0; dv_num = '0; dv_den = '0;
        mu_start = 1'b0; mu_a = '0; mu_b = '0;
        if (phase_reg == 3'd1) begin
            unique case (state_reg)
                ST_FADE: begin
                    dv_start = 1'b1;
                    dv_num = DN'({rem_f, 16'd0}) + DN'(fade_len_reg >> 1);
                    dv_den = DD'(fl_w);
                end
                ST_PH: begin
                    dv_start = 1'b1; dv_num = DN'(now_reg); dv_den = DD'(per_reg);
                end
                ST_X: begin
                    dv_start = 1'b1; dv_num = DN'(x_reg); dv_den = DD'(half_reg);
                end
                ST_X2: begin
                    mu_start = 1'b1; mu_a = x_reg; mu_b = x_reg[15:0];
                end
                ST_CUBE: begin
                    mu_start = 1'b1; mu_a = work_reg;
                    mu_b = 16'(3*PULSE_STEPS) - {x_reg[14:0], 1'b0};
                end
                ST_SQ: begin
                    mu_start = 1'b1; mu_a = work_reg; mu_b = work_reg[15:0];
                end
                ST_BR: begin
                    mu_start = 1'b1; mu_a = work_reg; mu_b = 16'(MAX_STATUS_BRIGHTNESS);
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for idle_sleep_fade_breathe.
// Drives timestamped ticks through the stream ports and checks every result
// beat against a local model of the idle/fade/sleep modes; needs isfb_pkg.
`timescale 1ns / 1ps

class sleep_scoreboard;
    logic [9:0]  tmo_min;
    logic [15:0] fade_len;
    logic [15:0] breathe_per;
    logic [31:0] last_act;
    logic [31:0] fade_start;
    bit          fading;
    bit          sleeping;
    logic [26:0] pending[$];
    int          errors;
    int          mismatches;

    function new();
        tmo_min = 0;
        fade_len = isfb_pkg::FADE_RESET;
        breathe_per = isfb_pkg::BREATHE_RESET;
        last_act = 0;
        fade_start = 0;
        fading = 0;
        sleeping = 0;
        errors = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            isfb_pkg::REG_TIMEOUT: tmo_min = val[9:0];
            isfb_pkg::REG_FADE:    fade_len = val;
            isfb_pkg::REG_BREATHE: breathe_per = val;
            default: ;
        endcase
    endfunction

    function logic [7:0] breathe_level(logic [31:0] now);
        longint unsigned s, p, h, ph, r, x, sm, lvl;
        s = 1024;
        p = (breathe_per < 2) ? 2 : breathe_per;
        h = p / 2;
        ph = now % p;
        r = (ph < h) ? ph : p - ph;
        x = r * s / h;
        if (x > s) x = s;
        sm = (x * x * (3 * s - 2 * x) + s * s / 2) / (s * s);
        lvl = (sm * sm + s / 2) / s;
        return 8'((lvl * 255 + s / 2) / s);
    endfunction

    // Update the modes for one tick and queue {tuser, pulse, scale}.
    function void note_tick(logic [31:0] now, bit act);
        logic [31:0] limit;
        longint unsigned e, f, scale;
        logic [7:0] pulse;
        limit = (tmo_min == 0) ? isfb_pkg::DEFAULT_IDLE_MS : tmo_min * 32'd60000;
        if (act) begin
            last_act = now;
            fading = 0;
            sleeping = 0;
        end else if (sleeping) begin
        end else if (fading) begin
            if (32'(now - fade_start) >= fade_len) begin
                fading = 0;
                sleeping = 1;
            end
        end else if (32'(now - last_act) >= limit) begin
            fading = 1;
            fade_start = now;
        end
        e = 32'(now - fade_start);
        f = fade_len;
        if (sleeping) scale = 0;
        else if (!fading) scale = 65536;
        else if (e >= f) scale = 0;
        else scale = ((f - e) * 65536 + f / 2) / f;
        pulse = sleeping ? breathe_level(now) : 8'd0;
        pending.push_back({fading, sleeping, pulse, scale[16:0]});
    endfunction

    function void check_beat(logic [31:0] data, logic [1:0] user);
        logic [26:0] want, got;
        got = {user, data[24:0]};
        if (pending.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat data=%h user=%b", data, user);
            return;
        end
        want = pending.pop_front();
        if (got !== want || data[31:25] !== 7'd0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp sleep=%b fade=%b scale=%0d pulse=%0d,",
                          " got sleep=%b fade=%b scale=%0d pulse=%0d"},
                         want[25], want[26], want[16:0], want[24:17],
                         user[0], user[1], data[16:0], data[24:17]);
        end
    endfunction
endclass

module tb_top;
    import isfb_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [15:0] cfg_wdata = 0;

    sleep_scoreboard sb = new();
    logic [31:0] clock_ms = 0;
    bit          hold_off = 0;

    idle_sleep_fade_breathe dut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // Keep tvalid high across back-to-back beats; drop it only for a gap.
    task automatic send_tick(logic [31:0] now, bit act, int gap);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= now;
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(now, act);
    endtask

    // Advance the clock by dt ms and send one tick.
    task automatic tick_after(int unsigned dt, bit act, int gap);
        clock_ms = clock_ms + dt;
        send_tick(clock_ms, act, gap);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // Idle through a whole timeout, fade and part of sleep with random gaps.
    task automatic sleep_cycle(int n);
        int unsigned dt;
        tick_after(1, 1, $urandom_range(0, 18));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: dt = $urandom_range(100000, 700000);
                1: dt = $urandom;
                2, 3: dt = $urandom_range(0, 3);
                default: dt = $urandom_range(1, 400);
            endcase
            tick_after(dt, ($urandom_range(0, 59) == 0), $urandom_range(0, 18));
        end
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
    end

    initial begin : receiver
        int wait_n;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (wait_n > 0) begin
                m_tready <= 0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : limit
        #200ms;
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] fades[4];
        logic [15:0] periods[4];
        fades = '{16'd0, 16'd1, 16'd65535, 16'd800};
        periods = '{16'd0, 16'd3, 16'd65535, 16'd4800};
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes of time, activity, default timeout, full fade
        send_tick(32'd0, 0, 0);
        send_tick(32'hFFFF_FFFF, 0, 0);
        send_tick(32'hFFFF_FFFF, 1, 1);
        send_tick(32'd299998, 0, 0);
        send_tick(32'd299999, 0, 0);
        send_tick(32'd300400, 0, 2);
        send_tick(32'd300799, 0, 0);
        send_tick(32'd300800, 0, 0);
        send_tick(32'd301000, 0, 0);
        send_tick(32'd303401, 0, 0);
        send_tick(32'd303401, 1, 0);
        drain();
        write_reg(REG_FADE, 16'd0);
        write_reg(REG_BREATHE, 16'd1);
        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_tick(32'd363401, 0, 0);
        send_tick(32'd363401, 0, 0);
        send_tick(32'd363402, 0, 0);
        send_tick(32'd363403, 0, 0);
        drain();
        write_reg(REG_TIMEOUT, 16'hFFFF);
        clock_ms = 32'd363403;
        drain();

        // random phases across register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_TIMEOUT, (ph % 4 == 0) ? 16'd0 : 16'($urandom_range(0, 3)));
            write_reg(REG_FADE, fades[ph % 4]);
            write_reg(REG_BREATHE, periods[$urandom_range(0, 3)]);
            if (ph == 3) hold_off = 1;
            for (int k = 0; k < 5; k++) sleep_cycle(49);
            if (ph == 5) drain();
            drain();
            write_reg(REG_FADE, 16'($urandom));
            write_reg(REG_BREATHE, 16'($urandom));
            drain();
        end

        drain();
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/isfb_pkg.sv
rtl/core/isfb_divider.sv
rtl/core/isfb_multiplier.sv
rtl/core/idle_sleep_fade_breathe.sv
tb/tb_top.sv
